// File: rtl/dfe_pkg.sv
// Shared types, constants and helpers for the delimited field extractor.
// Used by dfe_cell, dfe_cell_row and delimited_field_extractor; no dependencies.
package dfe_pkg;

    localparam int MAX_MARKER = 8;
    localparam int MAX_LEN    = 65536;
    localparam int POS_W      = 17;
    localparam int LEN_W      = 4;
    localparam int PAT_W      = 8 * MAX_MARKER;
    localparam int IDX_W      = (MAX_MARKER > 1) ? $clog2(MAX_MARKER) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        PH_BEGIN,
        PH_END,
        PH_FOUND,
        PH_LONG
    } t_phase;

    typedef enum logic [1:0] {
        ST_NOT_FOUND,
        ST_FOUND,
        ST_TOO_LONG
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEGIN_PATTERN,
        CFG_BEGIN_LENGTH,
        CFG_END_PATTERN,
        CFG_END_LENGTH
    } t_cfg_index;

    // Partial match bits carried along the cell row.
    typedef struct packed {
        logic bm;
        logic em;
    } t_match;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] max_len;
        max_len = LEN_W'(MAX_MARKER);
        return (len > max_len) ? max_len : len;
    endfunction

endpackage

// File: rtl/delimited_field_extractor.sv
// Delimited field extractor: top level with config registers, search FSM and result register.
// Depends on dfe_pkg and dfe_cell_row.
//
// Takes one buffer byte per cycle while the input is not stalled, with no gap between
// buffers. Marker matching runs in a row of eight compare cells that pass partial-match
// bits along as each byte is accepted. The result for a buffer is loaded into
// the output register on the cycle its last byte transfers and is shown the cycle
// after; input stalls only while a result waits and the consumer is not ready.
// Configuration writes are taken every cycle and apply from the next byte.
module delimited_field_extractor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [dfe_pkg::POS_W-1:0]       o_field_offset,
    output logic [dfe_pkg::POS_W-1:0]       o_field_length
);
    import dfe_pkg::*;

    logic [PAT_W-1:0] r_begin_pat;
    logic [LEN_W-1:0] r_begin_len;
    logic [PAT_W-1:0] r_end_pat;
    logic [LEN_W-1:0] r_end_len;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_end_pos, n_end_pos;

    logic             r_out_valid;
    logic [1:0]       r_status, n_status;
    logic [POS_W-1:0] r_offset, n_offset;
    logic [POS_W-1:0] r_length, n_length;

    logic                  w_acc;
    logic                  w_long;
    logic                  w_advance;
    logic                  w_clear;
    logic [POS_W-1:0]      w_pos_inc;
    logic [LEN_W-1:0]      w_bl, w_el, w_bl_m1, w_el_m1;
    logic                  w_end_enable;
    logic                  w_begin_hit, w_end_hit;
    logic [MAX_MARKER-1:0] w_begin_hits, w_end_hits;
    t_phase                w_phase_step;
    logic [POS_W-1:0]      w_start_step, w_end_step, w_pos_step;

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_pat <= '0;
            r_begin_len <= '0;
            r_end_pat   <= '0;
            r_end_len   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BEGIN_PATTERN: r_begin_pat <= i_cfg_data[PAT_W-1:0];
                CFG_BEGIN_LENGTH:  r_begin_len <= i_cfg_data[LEN_W-1:0];
                CFG_END_PATTERN:   r_end_pat   <= i_cfg_data[PAT_W-1:0];
                CFG_END_LENGTH:    r_end_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_long     = (r_pos == POS_W'(MAX_LEN));
    assign w_advance  = w_acc && !w_long;
    assign w_clear    = w_acc && i_last_byte;
    assign w_pos_inc  = r_pos + POS_W'(1);

    assign w_bl    = eff_len(r_begin_len);
    assign w_el    = eff_len(r_end_len);
    assign w_bl_m1 = w_bl - LEN_W'(1);
    assign w_el_m1 = w_el - LEN_W'(1);

    // with an empty begin marker the end search starts at the first byte
    assign w_end_enable = (r_phase == PH_END) ||
                          ((r_phase == PH_BEGIN) && (w_bl == '0));

    dfe_cell_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_clear      (w_clear),
        .i_byte       (i_data_byte),
        .i_begin_pat  (r_begin_pat),
        .i_end_pat    (r_end_pat),
        .i_end_enable (w_end_enable),
        .o_begin_hits (w_begin_hits),
        .o_end_hits   (w_end_hits)
    );

    assign w_begin_hit = (w_bl != '0) && w_begin_hits[w_bl_m1[IDX_W-1:0]];
    assign w_end_hit   = (w_el != '0) && w_end_enable && w_end_hits[w_el_m1[IDX_W-1:0]];

    // search FSM
    always_comb begin
        w_phase_step = r_phase;
        w_start_step = r_start;
        w_end_step   = r_end_pos;
        w_pos_step   = r_pos;
        if (w_long) begin
            w_phase_step = PH_LONG;
        end else begin
            w_pos_step = w_pos_inc;
            case (r_phase)
                PH_BEGIN: begin
                    if (w_bl == '0) begin
                        w_start_step = '0;
                        w_phase_step = PH_END;
                    end else if (w_begin_hit) begin
                        w_start_step = w_pos_inc;
                        w_phase_step = PH_END;
                    end
                end
                default: ;
            endcase
            if (w_end_hit) begin
                w_end_step   = w_pos_inc - POS_W'(w_el);
                w_phase_step = PH_FOUND;
            end
        end

        n_status = ST_NOT_FOUND;
        n_offset = '0;
        n_length = '0;
        case (w_phase_step)
            PH_LONG: begin
                n_status = ST_TOO_LONG;
            end
            PH_FOUND: begin
                n_status = ST_FOUND;
                n_offset = w_start_step;
                n_length = w_end_step - w_start_step;
            end
            PH_END: begin
                if (w_el == '0) begin
                    n_status = ST_FOUND;
                    n_offset = w_start_step;
                    n_length = w_pos_step - w_start_step;
                end
            end
            default: ;
        endcase

        n_phase   = r_phase;
        n_pos     = r_pos;
        n_start   = r_start;
        n_end_pos = r_end_pos;
        if (w_clear) begin
            n_phase   = PH_BEGIN;
            n_pos     = '0;
            n_start   = '0;
            n_end_pos = '0;
        end else if (w_acc) begin
            n_phase   = w_phase_step;
            n_pos     = w_pos_step;
            n_start   = w_start_step;
            n_end_pos = w_end_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_BEGIN;
            r_pos     <= '0;
            r_start   <= '0;
            r_end_pos <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_start   <= n_start;
            r_end_pos <= n_end_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_status <= n_status;
            r_offset <= n_offset;
            r_length <= n_length;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_field_offset = r_offset;
    assign o_field_length = r_length;

endmodule

// File: rtl/dfe_cell.sv
// One marker-compare cell: extends begin and end partial matches by one byte.
// Depends on dfe_pkg.
module dfe_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  logic          i_clear,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_begin_pat_byte,
    input  logic [7:0]    i_end_pat_byte,
    input  dfe_pkg::t_match i_prev,
    output dfe_pkg::t_match o_hit,
    output dfe_pkg::t_match o_link
);
    import dfe_pkg::*;

    t_match r_link;
    t_match n_link;

    always_comb begin
        o_hit.bm = i_prev.bm && (i_byte == i_begin_pat_byte);
        o_hit.em = i_prev.em && (i_byte == i_end_pat_byte);
        n_link   = r_link;
        if (i_clear) begin
            n_link = '0;
        end else if (i_advance) begin
            n_link = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

// File: rtl/dfe_cell_row.sv
// Row of marker-compare cells; cell k reports a match of the first k+1 marker bytes.
// Depends on dfe_pkg and dfe_cell.
module dfe_cell_row (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_clear,
    input  logic [7:0]                  i_byte,
    input  logic [dfe_pkg::PAT_W-1:0]   i_begin_pat,
    input  logic [dfe_pkg::PAT_W-1:0]   i_end_pat,
    input  logic                        i_end_enable,
    output logic [dfe_pkg::MAX_MARKER-1:0] o_begin_hits,
    output logic [dfe_pkg::MAX_MARKER-1:0] o_end_hits
);
    import dfe_pkg::*;

    t_match w_prev [MAX_MARKER];
    t_match w_hit  [MAX_MARKER];
    t_match w_link [MAX_MARKER];

    for (genvar k = 0; k < MAX_MARKER; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_prev[k].bm = 1'b1;
            assign w_prev[k].em = i_end_enable;
        end else begin : g_tail
            assign w_prev[k] = w_link[k-1];
        end

        dfe_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_advance        (i_advance),
            .i_clear          (i_clear),
            .i_byte           (i_byte),
            .i_begin_pat_byte (i_begin_pat[8*k +: 8]),
            .i_end_pat_byte   (i_end_pat[8*k +: 8]),
            .i_prev           (w_prev[k]),
            .o_hit            (w_hit[k]),
            .o_link           (w_link[k])
        );

        assign o_begin_hits[k] = w_hit[k].bm;
        assign o_end_hits[k]   = w_hit[k].em;
    end

endmodule
